@@ hw/rtl/port_scan_source_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Port scan source tracker assertion macros
// Concurrent checks on clock, disabled while reset is high. The checks drop
// out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PORT_SCAN_SOURCE_TRACKER_ASSERT_SVH
`define PORT_SCAN_SOURCE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PST_CHECK(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: name");
// next-cycle implication
`define PST_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: name");
`else
`define PST_CHECK(name, ante, cons)
`define PST_CHECK_NEXT(name, ante, cons)
`endif
`endif

@@ hw/rtl/pst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port scan source tracker package
// Table geometry, field types, status codes and shared helpers.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int HOST_LIMIT    = 16;
   localparam int PORT_LIMIT    = 16;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int HLANE_W       = $clog2(HOST_LIMIT);
   localparam int PLANE_W       = $clog2(PORT_LIMIT);
   localparam int MAX_LIMIT     = (HOST_LIMIT > PORT_LIMIT) ? HOST_LIMIT : PORT_LIMIT;
   localparam int CNT_W         = $clog2(MAX_LIMIT + 2);
   localparam int REMOVED_W     = $clog2(TABLE_ENTRIES + 1);

   localparam logic [15:0] EXPIRE_RESET = 16'd300;
   localparam logic [15:0] NO_PORT      = 16'hFFFF;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 120;

   typedef enum logic [1:0] {
      ST_UPDATED = 2'd0,
      ST_NEW     = 2'd1,
      ST_FULL    = 2'd2,
      ST_TICK    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MATCH,
      BK_LOOK,
      BK_UPDATE,
      BK_TICK_RD,
      BK_TICK_CHK,
      BK_TICK_DONE
   } back_state_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic        tick;
      logic [31:0] now_seconds;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] dest_port;
      logic [15:0] packet_length;
   } item_type;

   typedef struct packed {
      logic [31:0]      last_seen;
      logic [CNT_W-1:0] host_count;
      logic [CNT_W-1:0] port_count;
      logic [31:0]      packets;
      logic [31:0]      bytes;
   } record_type;

   typedef struct packed {
      status_type  status;
      logic        alert;
      logic [31:0] alert_source;
      logic [4:0]  host_count;
      logic [4:0]  port_count;
      logic [31:0] packet_count;
      logic [31:0] byte_count;
      logic [6:0]  expired_count;
   } result_type;

   // lowest set bit of a slot vector
   function automatic logic [SLOT_W-1:0] lowest_one(input logic [TABLE_ENTRIES-1:0] vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ hw/rtl/pst_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port scan source tracker front end
// Accept request beats, substitute the port for non TCP/UDP packets and
// queue the items in a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module pst_front import pst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  item_valid,
   input  logic                  item_ready,
   output item_type              item
);

   item_type    queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   item_type    cls;
   logic        push, pop;

   always_comb begin
      cls.tick           = req_tuser;
      cls.now_seconds    = req_tdata[31:0];
      cls.source_address = req_tdata[63:32];
      cls.dest_address   = req_tdata[95:64];
      cls.packet_length  = req_tdata[135:120];
      if (req_tdata[103:96] == PROTO_TCP || req_tdata[103:96] == PROTO_UDP) begin
         cls.dest_port = req_tdata[119:104];
      end else begin
         cls.dest_port = NO_PORT;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ hw/rtl/pst_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port scan source tracker back end
// Source tag match, entry read-modify-write, expiry sweep and result register.
// ----------------------------------------------------------------------------
module pst_back import pst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] expire_seconds,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp
);

   back_state_type state_ff, state_in;
   item_type       item_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]    source_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] match_ff, free_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic           found_ff, found_in, freed_ff, freed_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [REMOVED_W-1:0] removed_ff, removed_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff, rsp_in;

   record_type     rec_mem [TABLE_ENTRIES];
   logic [HOST_LIMIT-1:0][31:0] host_mem [TABLE_ENTRIES];
   logic [PORT_LIMIT-1:0][15:0] port_mem [TABLE_ENTRIES];
   record_type     rec_rd_ff;
   logic [HOST_LIMIT-1:0][31:0] host_rd_ff;
   logic [PORT_LIMIT-1:0][15:0] port_rd_ff;

   logic           rd_en, mem_we, src_we;
   logic [SLOT_W-1:0] rd_addr;
   record_type     rec_wr;
   logic [HOST_LIMIT-1:0][31:0] host_wr;
   logic [PORT_LIMIT-1:0][15:0] port_wr;
   logic           out_free;

   // update datapath
   logic           host_seen, port_seen, frozen, alert;
   logic [CNT_W-1:0] hc_n, pc_n;
   logic [31:0]    age;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign age       = item_ff.now_seconds - rec_rd_ff.last_seen;

   always_comb begin
      host_seen = 1'b0;
      port_seen = 1'b0;
      for (int i = 0; i < HOST_LIMIT; i++) begin
         if (CNT_W'(i) < rec_rd_ff.host_count && host_rd_ff[i] == item_ff.dest_address) begin
            host_seen = 1'b1;
         end
      end
      for (int i = 0; i < PORT_LIMIT; i++) begin
         if (CNT_W'(i) < rec_rd_ff.port_count && port_rd_ff[i] == item_ff.dest_port) begin
            port_seen = 1'b1;
         end
      end
      frozen  = rec_rd_ff.host_count > CNT_W'(HOST_LIMIT) ||
                rec_rd_ff.port_count > CNT_W'(PORT_LIMIT);
      host_wr = host_rd_ff;
      port_wr = port_rd_ff;
      hc_n    = rec_rd_ff.host_count;
      pc_n    = rec_rd_ff.port_count;
      alert   = 1'b0;
      if (!found_ff) begin
         host_wr[0] = item_ff.dest_address;
         port_wr[0] = item_ff.dest_port;
         hc_n       = CNT_W'(1);
         pc_n       = CNT_W'(1);
      end else if (!frozen) begin
         if (!host_seen && rec_rd_ff.host_count < CNT_W'(HOST_LIMIT)) begin
            host_wr[rec_rd_ff.host_count[HLANE_W-1:0]] = item_ff.dest_address;
            hc_n = rec_rd_ff.host_count + CNT_W'(1);
         end
         if (!port_seen && rec_rd_ff.port_count < CNT_W'(PORT_LIMIT)) begin
            port_wr[rec_rd_ff.port_count[PLANE_W-1:0]] = item_ff.dest_port;
            pc_n = rec_rd_ff.port_count + CNT_W'(1);
         end
         if (hc_n == CNT_W'(HOST_LIMIT) || pc_n == CNT_W'(PORT_LIMIT)) begin
            hc_n  = hc_n + CNT_W'(1);
            pc_n  = pc_n + CNT_W'(1);
            alert = 1'b1;
         end
      end
      rec_wr.last_seen  = item_ff.now_seconds;
      rec_wr.host_count = hc_n;
      rec_wr.port_count = pc_n;
      if (found_ff) begin
         rec_wr.packets = rec_rd_ff.packets + 32'd1;
         rec_wr.bytes   = rec_rd_ff.bytes + {16'd0, item_ff.packet_length};
      end else begin
         rec_wr.packets = 32'd1;
         rec_wr.bytes   = {16'd0, item_ff.packet_length};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      freed_in     = freed_ff;
      idx_in       = idx_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      item_ready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = slot_ff;
      mem_we       = 1'b0;
      src_we       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               idx_in     = '0;
               removed_in = '0;
               state_in   = item.tick ? BK_TICK_RD : BK_MATCH;
            end
         end
         BK_MATCH: begin
            state_in = BK_LOOK;
         end
         BK_LOOK: begin
            found_in = |match_ff;
            freed_in = |free_ff;
            slot_in  = found_in ? lowest_one(match_ff) : lowest_one(free_ff);
            rd_addr  = slot_in;
            rd_en    = 1'b1;
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.alert_source = item_ff.source_address;
               if (!found_ff && !freed_ff) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  mem_we              = 1'b1;
                  src_we              = !found_ff;
                  valid_in[slot_ff]   = 1'b1;
                  rsp_in.status       = found_ff ? ST_UPDATED : ST_NEW;
                  rsp_in.alert        = alert;
                  rsp_in.host_count   = 5'(hc_n);
                  rsp_in.port_count   = 5'(pc_n);
                  rsp_in.packet_count = rec_wr.packets;
                  rsp_in.byte_count   = rec_wr.bytes;
               end
               state_in = BK_IDLE;
            end
         end
         BK_TICK_RD: begin
            rd_addr  = idx_ff;
            rd_en    = 1'b1;
            state_in = BK_TICK_CHK;
         end
         BK_TICK_CHK: begin
            if (valid_ff[idx_ff] && age >= {16'd0, expire_seconds}) begin
               valid_in[idx_ff] = 1'b0;
               removed_in       = removed_ff + REMOVED_W'(1);
            end
            if (idx_ff == SLOT_W'(TABLE_ENTRIES - 1)) begin
               state_in = BK_TICK_DONE;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = BK_TICK_RD;
            end
         end
         BK_TICK_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.status        = ST_TICK;
               rsp_in.expired_count = 7'(removed_ff);
               state_in             = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && item_valid) begin
         item_ff <= item;
      end
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         match_ff[e] <= valid_ff[e] && source_ff[e] == item_ff.source_address;
      end
      free_ff    <= ~valid_ff;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      freed_ff   <= freed_in;
      idx_ff     <= idx_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
      if (src_we) begin
         source_ff[slot_ff] <= item_ff.source_address;
      end
   end

   // entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[slot_ff]  <= rec_wr;
         host_mem[slot_ff] <= host_wr;
         port_mem[slot_ff] <= port_wr;
      end
      if (rd_en) begin
         rec_rd_ff  <= rec_mem[rd_addr];
         host_rd_ff <= host_mem[rd_addr];
         port_rd_ff <= port_mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/port_scan_source_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port scan source tracker
// Per-source table of distinct destination hosts and ports with scan alerts.
// ----------------------------------------------------------------------------
// Each request beat is either a packet observation (req_tuser = 0) or an
// expiry tick (req_tuser = 1) and yields exactly one response beat. In the
// back end a packet goes through tag compare of all 64 sources, priority
// pick of the matching or first free slot with the entry read, then the
// read-modify-write of the entry record, host row and port row through one
// memory port. A tick walks the table entry by entry through the same port.
// The front end queues two further beats, and the response register lets the
// next item start while a result waits. The user must write expire_seconds
// on the csr channel only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module port_scan_source_tracker import pst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = now_seconds, source_address, dest_address,
   //          ip_protocol, dest_port, packet_length (lowest bit up)
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,    // mode
   // response: tdata = alert, alert_source, host_count, port_count,
   //           packet_count, byte_count, expired_count, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,    // status
   // expire_seconds write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   logic [15:0] expire_ff;
   logic        item_valid, item_ready;
   item_type    item;
   result_type  result;

   // hold the idle timeout; each write is registered and takes effect in the next cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expire_ff <= EXPIRE_RESET;
      end else if (csr_valid) begin
         expire_ff <= csr_data;
      end
   end

   pst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   pst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .expire_seconds (expire_ff),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp            (result)
   );

   // pack the result beat
   assign rsp_tuser = result.status;
   assign rsp_tdata = {6'd0, result.expired_count, result.byte_count, result.packet_count,
                       result.port_count, result.host_count, result.alert_source,
                       result.alert};

`include "port_scan_source_tracker_assert.svh"

   `PST_CHECK(a_alert_only_on_update, rsp_tvalid && rsp_tdata[0], rsp_tuser == ST_UPDATED)
   `PST_CHECK(a_full_has_no_counts, rsp_tvalid && rsp_tuser == ST_FULL, rsp_tdata[106:33] == '0)
   `PST_CHECK(a_tick_count_bounded, rsp_tvalid && rsp_tuser == ST_TICK, rsp_tdata[113:107] <= 7'(TABLE_ENTRIES))
   `PST_CHECK_NEXT(a_csr_write_lands, csr_valid && csr_ready, expire_ff == $past(csr_data))

endmodule
